[hdl/u16to8_pkg.sv]
// ============================================================================
// u16to8_pkg
// Shared types, constants and UTF-8 byte helpers for the UTF-16 to UTF-8
// transcoder.
// ============================================================================
`default_nettype none

package u16to8_pkg;

   // Default depth of the job queue between the front and the back.
   localparam int QueueDepth = 4;

   // Code point width: the largest code point is 0x10FFFF.
   localparam int CpWidth = 21;

   // Surrogate ranges, compared on the upper six bits of a code unit.
   localparam logic [5:0] HighSurrogateTag = 6'b110110;  // 0xD800 to 0xDBFF
   localparam logic [5:0] LowSurrogateTag  = 6'b110111;  // 0xDC00 to 0xDFFF

   // Upper limits of the 1, 2 and 3 byte encodings.
   localparam logic [CpWidth-1:0] Max1Byte = 21'h00007F;
   localparam logic [CpWidth-1:0] Max2Byte = 21'h0007FF;
   localparam logic [CpWidth-1:0] Max3Byte = 21'h00FFFF;

   // Lead and continuation prefixes.
   localparam logic [7:0] Lead2Prefix = 8'hC0;
   localparam logic [7:0] Lead3Prefix = 8'hE0;
   localparam logic [7:0] Lead4Prefix = 8'hF0;
   localparam logic [7:0] ContPrefix  = 8'h80;

   // Offset of the high surrogate's ten bits that yields plane bits (0x10000 >> 10).
   localparam logic [10:0] PlaneOffset = 11'h040;

   // One queued job: a first code point and an optional second BMP code unit.
   typedef struct packed {
      logic [CpWidth-1:0] first_cp;
      logic               second_valid;
      logic [15:0]        second_cp;
   } job_type;

   // Index of the final byte of a code point's encoding (length minus one).
   function automatic logic [1:0] last_index(input logic [CpWidth-1:0] cp);
      logic [1:0] result;
      begin
         if (cp <= Max1Byte) begin
            result = 2'd0;
         end else if (cp <= Max2Byte) begin
            result = 2'd1;
         end else if (cp <= Max3Byte) begin
            result = 2'd2;
         end else begin
            result = 2'd3;
         end
         return result;
      end
   endfunction

   // Byte number idx of the encoding of cp, whose final byte index is last.
   function automatic logic [7:0] utf8_byte(input logic [CpWidth-1:0] cp,
                                            input logic [1:0]         last,
                                            input logic [1:0]         idx);
      logic [1:0] pos;
      logic [5:0] seg;
      logic [7:0] result;
      begin
         pos = last - idx;
         unique case (pos)
            2'd0:    seg = cp[5:0];
            2'd1:    seg = cp[11:6];
            2'd2:    seg = cp[17:12];
            default: seg = {3'b000, cp[20:18]};
         endcase
         if (idx == 2'd0) begin
            unique case (last)
               2'd0:    result = {1'b0, cp[6:0]};
               2'd1:    result = Lead2Prefix | {3'b000, cp[10:6]};
               2'd2:    result = Lead3Prefix | {4'b0000, cp[15:12]};
               default: result = Lead4Prefix | {5'b00000, cp[20:18]};
            endcase
         end else begin
            result = ContPrefix | {2'b00, seg};
         end
         return result;
      end
   endfunction

endpackage

`default_nettype wire

[hdl/utf16_to_utf8_transcoder_unit.sv]
// ============================================================================
// utf16_to_utf8_transcoder_unit
// UTF-16 code units in, UTF-8 bytes out, with surrogate pairing.
// ============================================================================
//
//   Channel   Direction   Handshake            Payload
//   req_      in          req_valid/req_stall  code_unit[15:0], end_of_string
//   rsp_      out         rsp_valid/rsp_stall  out_byte[7:0], last_of_run
//
// The output gives one byte per cycle while the receiver does not stall, so
// an item puts as many bytes through the byte serializer as it causes: none
// for a stored high surrogate, one to four for a code point, up to six when
// an unpaired held surrogate goes out ahead of the new unit.
// A job queue of QUEUE_DEPTH entries lets items enter while bytes drain.
// Reset is synchronous and leaves nothing held and the queue empty.
// A stalled output holds its byte; the input stalls only when the queue is full.
// ============================================================================
`default_nettype none

module utf16_to_utf8_transcoder_unit #(
   parameter int QUEUE_DEPTH = u16to8_pkg::QueueDepth
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [15:0] req_code_unit,
   input  wire logic        req_end_of_string,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last_of_run
);

   u16to8_pkg::job_type push_job;
   u16to8_pkg::job_type head_job;
   logic                push;
   logic                queue_full;
   logic                pop;
   logic                head_valid;

   u16to8_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_code_unit     (req_code_unit),
      .req_end_of_string (req_end_of_string),
      .queue_full        (queue_full),
      .push              (push),
      .job               (push_job)
   );

   u16to8_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   u16to8_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_job        (head_job),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire

[hdl/u16to8_front.sv]
// ============================================================================
// u16to8_front
// Accepts code units, pairs surrogates and turns each item into at most one
// job for the serializer.
// ============================================================================
`default_nettype none

module u16to8_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [15:0]          req_code_unit,
   input  wire logic                 req_end_of_string,
   input  wire logic                 queue_full,
   output logic                      push,
   output u16to8_pkg::job_type       job
);

   logic       held_valid_ff;
   logic       held_valid_in;
   logic [9:0] held_bits_ff;
   logic [9:0] held_bits_in;
   logic       accept;
   logic       is_high;
   logic       is_low;
   logic       hold_new;

   // Classify the incoming unit.
   assign accept   = req_valid && !queue_full;
   assign req_stall = queue_full;
   assign is_high  = (req_code_unit[15:10] == u16to8_pkg::HighSurrogateTag);
   assign is_low   = (req_code_unit[15:10] == u16to8_pkg::LowSurrogateTag);
   assign hold_new = is_high && !req_end_of_string;

   // Build the job and the next held state.
   always_comb begin
      held_valid_in     = held_valid_ff;
      held_bits_in      = held_bits_ff;
      push              = 1'b0;
      job.first_cp      = {5'b00000, req_code_unit};
      job.second_valid  = 1'b0;
      job.second_cp     = req_code_unit;
      if (accept) begin
         if (held_valid_ff && is_low) begin
            // A completed pair gives one supplementary code point.
            push          = 1'b1;
            job.first_cp  = {(u16to8_pkg::PlaneOffset + {1'b0, held_bits_ff}),
                             req_code_unit[9:0]};
            held_valid_in = 1'b0;
            held_bits_in  = '0;
         end else if (held_valid_ff) begin
            // The held surrogate goes out alone, then the new unit unless it is held.
            push             = 1'b1;
            job.first_cp     = {5'b00000, u16to8_pkg::HighSurrogateTag, held_bits_ff};
            job.second_valid = !hold_new;
            held_valid_in    = hold_new;
            held_bits_in     = hold_new ? req_code_unit[9:0] : 10'd0;
         end else begin
            push          = !hold_new;
            held_valid_in = hold_new;
            held_bits_in  = hold_new ? req_code_unit[9:0] : 10'd0;
         end
      end
   end

   // Held surrogate register.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         held_bits_ff  <= '0;
      end else begin
         held_valid_ff <= held_valid_in;
         held_bits_ff  <= held_bits_in;
      end
   end

endmodule

`default_nettype wire

[hdl/u16to8_queue.sv]
// ============================================================================
// u16to8_queue
// Small job queue that decouples the front from the byte serializer.
// ============================================================================
`default_nettype none

module u16to8_queue #(
   parameter int QUEUE_DEPTH = u16to8_pkg::QueueDepth
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire u16to8_pkg::job_type  push_job,
   output logic                      full,
   input  wire logic                 pop,
   output logic                      head_valid,
   output u16to8_pkg::job_type       head_job
);

   localparam int PtrWidth   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CountWidth = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PtrWidth-1:0]   LastPtr   = PtrWidth'(QUEUE_DEPTH - 1);
   localparam logic [CountWidth-1:0] FullCount = CountWidth'(QUEUE_DEPTH);

   u16to8_pkg::job_type     entries_ff [QUEUE_DEPTH];
   logic [PtrWidth-1:0]     wr_ptr_ff;
   logic [PtrWidth-1:0]     wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff;
   logic [PtrWidth-1:0]     rd_ptr_in;
   logic [CountWidth-1:0]   count_ff;
   logic [CountWidth-1:0]   count_in;
   logic                    do_push;
   logic                    do_pop;

   assign full       = (count_ff == FullCount);
   assign head_valid = (count_ff != '0);
   assign head_job   = entries_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

[hdl/u16to8_back.sv]
// ============================================================================
// u16to8_back
// Byte serializer: walks the code points of each job and drives one UTF-8
// byte per cycle, unless the output stalls, into the output register.
// ============================================================================
`default_nettype none

module u16to8_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 head_valid,
   input  wire u16to8_pkg::job_type  head_job,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_last_of_run
);

   localparam int CpW = u16to8_pkg::CpWidth;

   logic            busy_ff;
   logic            busy_in;
   logic [CpW-1:0]  cp_ff;
   logic [CpW-1:0]  cp_in;
   logic [1:0]      idx_ff;
   logic [1:0]      idx_in;
   logic            sec_valid_ff;
   logic            sec_valid_in;
   logic [15:0]     sec_cp_ff;
   logic [15:0]     sec_cp_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic [7:0]      rsp_byte_ff;
   logic [7:0]      rsp_byte_in;
   logic            rsp_last_ff;
   logic            rsp_last_in;
   logic [1:0]      last_idx;
   logic            at_end;
   logic            fire;
   logic            load;

   // The output register takes a new byte when empty or being drained.
   assign last_idx = u16to8_pkg::last_index(cp_ff);
   assign at_end   = (idx_ff == last_idx);
   assign fire     = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign load     = !busy_ff || (fire && at_end && !sec_valid_ff);
   assign pop      = load && head_valid;

   // Serializer state and output register next values.
   always_comb begin
      busy_in      = busy_ff;
      cp_in        = cp_ff;
      idx_in       = idx_ff;
      sec_valid_in = sec_valid_ff;
      sec_cp_in    = sec_cp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = u16to8_pkg::utf8_byte(cp_ff, last_idx, idx_ff);
         rsp_last_in  = at_end && !sec_valid_ff;
         if (!at_end) begin
            idx_in = idx_ff + 1'b1;
         end else if (sec_valid_ff) begin
            // Move on to the unit that followed an unpaired surrogate.
            cp_in        = {5'b00000, sec_cp_ff};
            idx_in       = 2'd0;
            sec_valid_in = 1'b0;
         end
      end
      if (load) begin
         busy_in      = head_valid;
         cp_in        = head_job.first_cp;
         idx_in       = 2'd0;
         sec_valid_in = head_job.second_valid;
         sec_cp_in    = head_job.second_cp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         sec_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         busy_ff      <= busy_in;
         sec_valid_ff <= sec_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cp_ff       <= cp_in;
      sec_cp_ff   <= sec_cp_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

`default_nettype wire

[hdl/u16to8_checker.sv]
// ============================================================================
// u16to8_checker
// Port-level checks on the transcoder: output framing and UTF-8 structure.
// ============================================================================
`default_nettype none

module u16to8_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [7:0]  rsp_out_byte,
   input wire logic        rsp_last_of_run
);

   logic       rsp_take;
   logic [1:0] remain_ff;
   logic [1:0] remain_in;

   assign rsp_take = rsp_valid && !rsp_stall;

   // Continuation bytes still owed by the character being sent.
   always_comb begin
      remain_in = remain_ff;
      if (rsp_take) begin
         if (remain_ff != 2'd0) begin
            remain_in = remain_ff - 1'b1;
         end else if (rsp_out_byte[7:5] == 3'b110) begin
            remain_in = 2'd1;
         end else if (rsp_out_byte[7:4] == 4'b1110) begin
            remain_in = 2'd2;
         end else if (rsp_out_byte[7:3] == 5'b11110) begin
            remain_in = 2'd3;
         end else begin
            remain_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
      end else begin
         remain_ff <= remain_in;
      end
   end

   // Reset empties the job queue and the output register.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("output item valid or input stalled right after reset");

   // A stalled output item keeps its byte and marker.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
                                 && $stable(rsp_last_of_run))
      else $error("stalled output item changed");

   // Continuation bytes appear exactly where a lead byte announced them.
   a_cont_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> ((remain_ff != 2'd0) == (rsp_out_byte[7:6] == 2'b10)))
      else $error("continuation byte out of place");

   // The final byte of an item also closes a character.
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_take && rsp_last_of_run |->
         (remain_ff == 2'd1) || (remain_ff == 2'd0 && !rsp_out_byte[7]))
      else $error("item ended inside a character");

endmodule

bind utf16_to_utf8_transcoder_unit u16to8_checker u_u16to8_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_out_byte      (rsp_out_byte),
   .rsp_last_of_run   (rsp_last_of_run)
);

`default_nettype wire

[tb/utf16_to_utf8_transcoder_unit_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// utf16_to_utf8_transcoder_unit_tb
// Self-checking bench for the UTF-16 to UTF-8 transcoder. Directed code
// units cover the encoding boundaries and every surrogate case, then random
// strings of plain characters and mostly well-formed surrogate pairs run under
// several idle and stall mixes, including a long receiver hold-off that fills
// the job queue. Every accepted byte is checked against a predicted UTF-8 stream.
// ============================================================================

module utf16_to_utf8_transcoder_unit_tb;

   localparam int HoldOffCycles = 120;
   localparam int DrainLimit    = 20000;

   // One predicted output item.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } utf8_out_type;

   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        req_valid         = 1'b0;
   logic        req_stall;
   logic [15:0] req_code_unit     = 16'h0000;
   logic        req_end_of_string = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall         = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last_of_run;

   // Predicted bytes in output order, and the predictor's surrogate state.
   utf8_out_type expected_bytes[$];
   utf8_out_type oldest;
   logic        pending_high_valid = 1'b0;
   logic [9:0]  pending_high_bits  = 10'h000;

   int          error_count   = 0;
   int          items_sent    = 0;
   int          req_idle_pct  = 0;
   int          rsp_stall_pct = 0;
   int          hold_requests = 0;
   int          holds_served  = 0;
   int          hold_left     = 0;
   int          drain_wait;

   utf16_to_utf8_transcoder_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_code_unit     (req_code_unit),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   // Free-running clock.
   initial begin
      forever #1 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #400000;
      $display("FAIL");
      $finish;
   end

   // Adds one byte at the tail of the expected stream.
   task automatic append_expected(input logic [7:0] value);
      utf8_out_type entry;
      entry.out_byte    = value;
      entry.last_of_run = 1'b0;
      expected_bytes.insert(expected_bytes.size(), entry);
   endtask

   // Appends the UTF-8 bytes of one code point to the expected stream.
   task automatic push_code_point(input logic [u16to8_pkg::CpWidth-1:0] cp);
      if (cp <= u16to8_pkg::Max1Byte) begin
         append_expected(cp[7:0]);
      end else if (cp <= u16to8_pkg::Max2Byte) begin
         append_expected(u16to8_pkg::Lead2Prefix | {3'b000, cp[10:6]});
         append_expected(u16to8_pkg::ContPrefix | {2'b00, cp[5:0]});
      end else if (cp <= u16to8_pkg::Max3Byte) begin
         append_expected(u16to8_pkg::Lead3Prefix | {4'b0000, cp[15:12]});
         append_expected(u16to8_pkg::ContPrefix | {2'b00, cp[11:6]});
         append_expected(u16to8_pkg::ContPrefix | {2'b00, cp[5:0]});
      end else begin
         append_expected(u16to8_pkg::Lead4Prefix | {5'b00000, cp[20:18]});
         append_expected(u16to8_pkg::ContPrefix | {2'b00, cp[17:12]});
         append_expected(u16to8_pkg::ContPrefix | {2'b00, cp[11:6]});
         append_expected(u16to8_pkg::ContPrefix | {2'b00, cp[5:0]});
      end
   endtask

   // Works out the bytes that one accepted code unit causes.
   task automatic predict_utf8(input logic [15:0] unit, input logic eos);
      int   depth_before;
      logic is_high;
      logic is_low;
      logic paired;
      depth_before = expected_bytes.size();
      is_high      = (unit[15:10] == u16to8_pkg::HighSurrogateTag);
      is_low       = (unit[15:10] == u16to8_pkg::LowSurrogateTag);
      paired       = 1'b0;
      if (pending_high_valid) begin
         pending_high_valid = 1'b0;
         if (is_low) begin
            // A complete pair forms one supplementary code point.
            push_code_point(21'h10000 + {pending_high_bits, unit[9:0]});
            paired = 1'b1;
         end else begin
            // An unpaired high surrogate goes out alone ahead of the new unit.
            push_code_point({5'b00000, u16to8_pkg::HighSurrogateTag, pending_high_bits});
         end
         pending_high_bits = 10'h000;
      end
      if (!paired) begin
         if (is_high && !eos) begin
            pending_high_valid = 1'b1;
            pending_high_bits  = unit[9:0];
         end else begin
            push_code_point({5'b00000, unit});
         end
      end
      if (expected_bytes.size() > depth_before) begin
         expected_bytes[expected_bytes.size()-1].last_of_run = 1'b1;
      end
   endtask

   // Predicts on each accepted input item and checks each accepted output item.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_utf8(req_code_unit, req_end_of_string);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               $display("%0t: unexpected byte: expected none, actual %h last %b",
                        $realtime, rsp_out_byte, rsp_last_of_run);
               error_count++;
            end else begin
               oldest = expected_bytes.pop_front();
               if (rsp_out_byte !== oldest.out_byte) begin
                  $display("%0t: out_byte mismatch: expected %h, actual %h",
                           $realtime, oldest.out_byte, rsp_out_byte);
                  error_count++;
               end
               if (rsp_last_of_run !== oldest.last_of_run) begin
                  $display("%0t: last_of_run mismatch: expected %b, actual %b",
                           $realtime, oldest.last_of_run, rsp_last_of_run);
                  error_count++;
               end
            end
         end
      end
   end

   // Receiver stall: random by percentage, or a long hold-off on request.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (holds_served != hold_requests) begin
         holds_served++;
         hold_left = HoldOffCycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Offers one item after a random gap and returns at the edge that takes it.
   task automatic send_unit(input logic [15:0] unit, input logic eos);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_code_unit     <= unit;
      req_end_of_string <= eos;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      items_sent++;
   endtask

   // Encoding boundaries and every surrogate case.
   task automatic test_directed_encodings();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      send_unit(16'h0000, 1'b0);
      send_unit(16'h007F, 1'b0);
      send_unit(16'h0080, 1'b0);
      send_unit(16'h07FF, 1'b0);
      send_unit(16'h0800, 1'b0);
      send_unit(16'hD7FF, 1'b0);
      send_unit(16'hE000, 1'b0);
      send_unit(16'hFFFF, 1'b1);
      // Surrogate pairs at both ends of the supplementary range.
      send_unit(16'hD800, 1'b0);
      send_unit(16'hDC00, 1'b0);
      send_unit(16'hDBFF, 1'b0);
      send_unit(16'hDFFF, 1'b1);
      // Held high surrogate followed by a character that does not pair.
      send_unit(16'hD800, 1'b0);
      send_unit(16'h0041, 1'b0);
      send_unit(16'hDA12, 1'b0);
      send_unit(16'h07FF, 1'b0);
      // Two high surrogates in a row, then a third at the end of the string.
      send_unit(16'hDA12, 1'b0);
      send_unit(16'hDB00, 1'b0);
      send_unit(16'hD9AB, 1'b1);
      // High surrogate alone at the end of a string, and lone low surrogates.
      send_unit(16'hDBFF, 1'b1);
      send_unit(16'hDC00, 1'b0);
      send_unit(16'hDFFF, 1'b1);
      // Held high surrogate followed by a three-byte character.
      send_unit(16'hD83D, 1'b0);
      send_unit(16'hFFFE, 1'b1);
   endtask

   // Random strings: mostly pairs and plain characters, some stray surrogates.
   task automatic test_random_strings(input int item_goal);
      int          first_item;
      int          kind;
      logic [15:0] unit;
      first_item = items_sent;
      while (items_sent - first_item < item_goal) begin
         kind = $urandom_range(99);
         if (kind < 40) begin
            send_unit({u16to8_pkg::HighSurrogateTag, 10'($urandom())},
                      ($urandom_range(15) == 0));
            send_unit({u16to8_pkg::LowSurrogateTag, 10'($urandom())},
                      ($urandom_range(7) == 0));
         end else begin
            if (kind < 55) begin
               unit = 16'($urandom_range(16'h007F));
            end else if (kind < 70) begin
               unit = 16'($urandom_range(16'h07FF, 16'h0080));
            end else if (kind < 85) begin
               unit = 16'($urandom_range(16'hFFFF, 16'h0800));
               // Move surrogate values out into the plain range.
               if (unit[15:11] == 5'b11011) begin
                  unit[15] = 1'b0;
               end
            end else if (kind < 93) begin
               unit = 16'($urandom_range(16'hDFFF, 16'hD800));
            end else begin
               unit = 16'($urandom());
            end
            send_unit(unit, ($urandom_range(7) == 0));
         end
      end
   endtask

   // Receiver holds off for a long stretch while the sender keeps offering.
   task automatic test_backpressure_fill();
      int idx;
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      hold_requests++;
      for (idx = 0; idx < 16; idx++) begin
         if (idx % 4 == 0) begin
            send_unit({u16to8_pkg::HighSurrogateTag, 10'($urandom())}, 1'b0);
            send_unit({u16to8_pkg::LowSurrogateTag, 10'($urandom())}, 1'b0);
         end else begin
            send_unit(16'h0800 | 16'($urandom_range(16'h57FF)), (idx == 15));
         end
      end
   endtask

   // Test sequence.
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_encodings();
      test_backpressure_fill();

      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      test_random_strings(16);
      req_idle_pct  = 67;
      rsp_stall_pct = 0;
      test_random_strings(16);
      req_idle_pct  = 0;
      rsp_stall_pct = 67;
      test_random_strings(16);
      req_idle_pct  = 30;
      rsp_stall_pct = 30;
      test_random_strings(16);
      send_unit(16'h0024, 1'b1);
      req_valid <= 1'b0;

      // Let the remaining bytes drain, then watch for stray output.
      drain_wait = 0;
      while (expected_bytes.size() != 0 && drain_wait < DrainLimit) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (40) @(posedge clock);
      if (expected_bytes.size() != 0) begin
         $display("%0t: %0d expected bytes never arrived, next expected %h",
                  $realtime, expected_bytes.size(), expected_bytes[0].out_byte);
         error_count++;
      end

      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
